[rtl/gdn_pkg.sv]
package gdn_pkg;

    // Field widths of the items
    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned YEAR_W    = 12;
    localparam int unsigned MONTH_W   = 4;
    localparam int unsigned MDAY_W    = 5;
    localparam int unsigned DAY_W     = 21;
    localparam int unsigned WD_W      = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned R400_W    = 9;

    // Calendar constants
    localparam logic [DAY_W-1:0]  YEAR_DAYS      = DAY_W'(365);
    localparam logic [DAY_W-1:0]  LEAP_YEAR_DAYS = DAY_W'(366);
    localparam logic [YEAR_W-1:0] CYCLE_YEARS    = YEAR_W'(400);
    localparam logic [R400_W-1:0] CYCLE_LAST     = R400_W'(399);
    localparam logic [R400_W-1:0] CENTURY        = R400_W'(100);
    localparam logic [MDAY_W-1:0] FEB_LEAP_DAYS  = MDAY_W'(29);
    localparam logic [MDAY_W-1:0] MDAY_MAX       = MDAY_W'(31);
    localparam logic [MONTH_W-1:0] DECEMBER_IDX  = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] FEBRUARY_IDX  = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] FULL_MONTHS   = MONTH_W'(12);
    localparam logic [3:0]        WEEK_DAYS      = 4'd7;
    localparam logic [4:0]        WD_BIAS        = 5'd5;

    // Reset values of the registers
    localparam logic [YEAR_W-1:0] EPOCH_RESET  = YEAR_W'(1900);
    localparam logic [YEAR_W-1:0] REFYR_RESET  = YEAR_W'(1900);
    localparam logic [WD_W-1:0]   REFWD_RESET  = WD_W'(2);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TO_COUNT = 2'd0,
        FUNC_TO_DATE  = 2'd1,
        FUNC_WEEKDAY  = 2'd2,
        FUNC_NONE     = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EPOCH_YEAR  = 2'd0,
        CFG_REF_YEAR    = 2'd1,
        CFG_REF_WEEKDAY = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [MDAY_W-1:0]  day;
        logic [DAY_W-1:0]   day_number;
    } cmd_t;

    typedef struct packed {
        logic [DAY_W-1:0]   day_count;
        logic [YEAR_W-1:0]  out_year;
        logic [MONTH_W-1:0] out_month;
        logic [MDAY_W-1:0]  out_day;
        logic [WD_W-1:0]    weekday;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [YEAR_W-1:0]    value;
    } cfg_t;

    // Operation for the shared add/subtract unit
    typedef struct packed {
        logic [DAY_W-1:0] a;
        logic [DAY_W-1:0] b;
        logic             sub;
        logic             cin;
    } alu_op_t;

    typedef struct packed {
        logic [DAY_W-1:0] sum;
        logic             carry;
    } alu_res_t;

    // Days in a month of a common year, month index 0 is January
    function automatic logic [MDAY_W-1:0] month_len(input logic [MONTH_W-1:0] mn);
        logic [MDAY_W-1:0] len;
        case (mn)
            4'd1:                   len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the first n months of a common year, n from 0 to 12
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] n);
        logic [8:0] d;
        case (n)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd365;
        endcase
        return d;
    endfunction

    // Leap rule on the year's position within the 400-year cycle
    function automatic logic leap_of(input logic [R400_W-1:0] r);
        return (r[1:0] == 2'b00) && (r != CENTURY) && (r != R400_W'(2 * CENTURY))
            && (r != R400_W'(3 * CENTURY));
    endfunction

endpackage

[rtl/gdn_stream_if.sv]
interface gdn_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/gdn_alu.sv]
module gdn_alu (
    input  gdn_pkg::alu_op_t  op,
    output gdn_pkg::alu_res_t res
);
    localparam int unsigned W = gdn_pkg::DAY_W;

    logic [W:0] total;

    // Add, or subtract with carry out meaning a >= b
    assign total = {1'b0, op.a} + {1'b0, op.b ^ {W{op.sub}}} + (W + 1)'(op.sub | op.cin);
    assign res.sum   = total[W-1:0];
    assign res.carry = total[W];
endmodule

[rtl/gregorian_day_number_converter.sv]
// Channel | Dir | Beat                                   | Handshake
// cmd     | in  | func, year, month, day, day_number     | valid/ready
// rsp     | out | day_count, out_year, out_month,        | valid/ready
//         |     | out_day, weekday                       |
// cfg     | in  | register index, value                  | valid/ready
//
// One beat at a time; cmd.ready is high only while the sequencer is idle.
// Date to day number: reduce the years into the 400-year cycle, then walk one year per
// cycle through the shared adder; weekday adds the S_MOD7 state to fold the count mod 7.
// Day number to date: walk the years, then the months up to December.
// The worst case is set by the year walk over the shared adder.
// cfg is always ready; a finished beat waits in the rsp register under stall
// while the next cmd beat may already be taken. Asynchronous active-low reset.
module gregorian_day_number_converter #(
    parameter int unsigned MAX_YEAR = 4095
) (
    input  logic                clk,
    input  logic                rst_n,
    gdn_stream_if.sink          cmd,
    gdn_stream_if.sink          cfg,
    gdn_stream_if.source        rsp
);
    localparam int unsigned YW = ($clog2(MAX_YEAR + 1) > gdn_pkg::YEAR_W)
                                 ? $clog2(MAX_YEAR + 1) : gdn_pkg::YEAR_W;
    localparam int unsigned AW = gdn_pkg::DAY_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MODY,
        S_INIT,
        S_MODB,
        S_YWALK,
        S_YWALK1,
        S_MWALK,
        S_MOD7,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [gdn_pkg::YEAR_W-1:0]  epoch_reg, epoch_next;
    logic [gdn_pkg::YEAR_W-1:0]  refyr_reg, refyr_next;
    logic [gdn_pkg::WD_W-1:0]    refwd_reg, refwd_next;

    gdn_pkg::func_t              func_reg, func_next;
    logic [gdn_pkg::YEAR_W-1:0]  year_reg, year_next;
    logic [gdn_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [gdn_pkg::MDAY_W-1:0]  day_reg, day_next;
    logic [gdn_pkg::YEAR_W-1:0]  r400_reg, r400_next;
    logic [YW-1:0]               k_reg, k_next;
    logic [AW-1:0]               acc_reg, acc_next;
    logic [gdn_pkg::MONTH_W-1:0] mn_reg, mn_next;
    logic [2:0]                  rem_reg, rem_next;

    gdn_pkg::rsp_t               out_reg, out_next;
    logic                        out_valid_reg, out_valid_next;

    gdn_pkg::alu_op_t            alu_op;
    gdn_pkg::alu_res_t           alu_res;

    logic                        leap;
    logic [gdn_pkg::R400_W-1:0]  r400_inc;
    logic [gdn_pkg::MONTH_W-1:0] months_done;
    logic [gdn_pkg::YEAR_W-1:0]  base_year;
    logic [gdn_pkg::MDAY_W-1:0]  mlen;
    logic [4:0]                  wd_sum;
    logic [4:0]                  wd_mod;
    logic [5:0]                  fold_sum;
    logic [3:0]                  fold_low;
    logic [2:0]                  count_mod7;
    logic                        slot_free;

    gdn_alu u_alu (
        .op  (alu_op),
        .res (alu_res)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Decode the cycle position, month count and month length
    assign leap      = gdn_pkg::leap_of(r400_reg[gdn_pkg::R400_W-1:0]);
    assign r400_inc  = (r400_reg[gdn_pkg::R400_W-1:0] == gdn_pkg::CYCLE_LAST)
                       ? '0 : r400_reg[gdn_pkg::R400_W-1:0] + 1'b1;
    assign base_year = (func_reg == gdn_pkg::FUNC_TO_COUNT) ? epoch_reg : refyr_reg;
    assign slot_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        if (month_reg == '0)
            months_done = '0;
        else if (month_reg > gdn_pkg::FULL_MONTHS)
            months_done = gdn_pkg::FULL_MONTHS;
        else
            months_done = month_reg - 1'b1;
    end

    always_comb
    begin
        if (mn_reg == gdn_pkg::FEBRUARY_IDX && leap)
            mlen = gdn_pkg::FEB_LEAP_DAYS;
        else
            mlen = gdn_pkg::month_len(mn_reg);
    end

    // Fold the day count mod 7: eight is one mod 7, so add the 3-bit groups
    always_comb
    begin
        fold_sum = 6'(acc_reg[2:0]) + 6'(acc_reg[5:3]) + 6'(acc_reg[8:6])
                   + 6'(acc_reg[11:9]) + 6'(acc_reg[14:12]) + 6'(acc_reg[17:15])
                   + 6'(acc_reg[20:18]);
        fold_low = 4'(fold_sum[2:0]) + 4'(fold_sum[5:3]);
        if (fold_low >= gdn_pkg::WEEK_DAYS)
            count_mod7 = 3'(fold_low - gdn_pkg::WEEK_DAYS);
        else
            count_mod7 = fold_low[2:0];
    end

    // Fold the day count remainder into a weekday 1 to 7
    assign wd_sum = 5'(rem_reg) + 5'(refwd_reg) + gdn_pkg::WD_BIAS;
    always_comb
    begin
        if (wd_sum >= 5'(2 * gdn_pkg::WEEK_DAYS))
            wd_mod = wd_sum - 5'(2 * gdn_pkg::WEEK_DAYS);
        else if (wd_sum >= 5'(gdn_pkg::WEEK_DAYS))
            wd_mod = wd_sum - 5'(gdn_pkg::WEEK_DAYS);
        else
            wd_mod = wd_sum;
    end

    // Sequencer and shared adder operand selection
    always_comb
    begin
        state_next     = state_reg;
        epoch_next     = epoch_reg;
        refyr_next     = refyr_reg;
        refwd_next     = refwd_reg;
        func_next      = func_reg;
        year_next      = year_reg;
        month_next     = month_reg;
        day_next       = day_reg;
        r400_next      = r400_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        mn_next        = mn_reg;
        rem_next       = rem_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        alu_op         = '0;

        // Write configuration registers
        if (cfg.valid)
        begin
            case (cfg.data.index)
                gdn_pkg::CFG_EPOCH_YEAR:  epoch_next = cfg.data.value;
                gdn_pkg::CFG_REF_YEAR:    refyr_next = cfg.data.value;
                gdn_pkg::CFG_REF_WEEKDAY: refwd_next = cfg.data.value[gdn_pkg::WD_W-1:0];
                default:                  ;
            endcase
        end

        // Drop the result once taken
        if (rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    func_next  = gdn_pkg::func_t'(cmd.data.func);
                    year_next  = cmd.data.year;
                    month_next = cmd.data.month;
                    day_next   = cmd.data.day;
                    acc_next   = cmd.data.day_number;
                    case (cmd.data.func)
                        gdn_pkg::FUNC_TO_DATE:
                        begin
                            r400_next  = epoch_reg;
                            k_next     = YW'(epoch_reg);
                            state_next = S_MODB;
                        end
                        gdn_pkg::FUNC_TO_COUNT, gdn_pkg::FUNC_WEEKDAY:
                        begin
                            r400_next  = cmd.data.year;
                            state_next = S_MODY;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end

            // Reduce the date's year into the 400-year cycle
            S_MODY:
            begin
                alu_op.a   = AW'(r400_reg);
                alu_op.b   = AW'(gdn_pkg::CYCLE_YEARS);
                alu_op.sub = 1'b1;
                if (alu_res.carry)
                    r400_next = alu_res.sum[gdn_pkg::YEAR_W-1:0];
                else
                    state_next = S_INIT;
            end

            // Start the count with whole months, day and leap day
            S_INIT:
            begin
                alu_op.a   = AW'(gdn_pkg::cum_days(months_done));
                alu_op.b   = AW'(day_reg);
                alu_op.cin = (month_reg > 4'd2) && leap;
                acc_next   = alu_res.sum;
                r400_next  = base_year;
                k_next     = YW'(base_year);
                state_next = S_MODB;
            end

            // Reduce the base year into the 400-year cycle
            S_MODB:
            begin
                alu_op.a   = AW'(r400_reg);
                alu_op.b   = AW'(gdn_pkg::CYCLE_YEARS);
                alu_op.sub = 1'b1;
                if (alu_res.carry)
                    r400_next = alu_res.sum[gdn_pkg::YEAR_W-1:0];
                else if (func_reg == gdn_pkg::FUNC_TO_DATE)
                    state_next = S_YWALK1;
                else
                    state_next = S_YWALK;
            end

            // Add one whole year per cycle up to the date's year
            S_YWALK:
            begin
                alu_op.a   = acc_reg;
                alu_op.b   = gdn_pkg::YEAR_DAYS;
                alu_op.cin = leap;
                if (k_reg < YW'(year_reg))
                begin
                    acc_next  = alu_res.sum;
                    k_next    = k_reg + 1'b1;
                    r400_next = gdn_pkg::YEAR_W'(r400_inc);
                end
                else if (func_reg == gdn_pkg::FUNC_WEEKDAY)
                    state_next = S_MOD7;
                else
                    state_next = S_DONE;
            end

            // Take off whole years while more days remain than the year holds
            S_YWALK1:
            begin
                alu_op.a   = acc_reg;
                alu_op.b   = leap ? gdn_pkg::LEAP_YEAR_DAYS : gdn_pkg::YEAR_DAYS;
                alu_op.sub = 1'b1;
                if (alu_res.carry && (alu_res.sum != '0) && (k_reg < YW'(MAX_YEAR)))
                begin
                    acc_next  = alu_res.sum;
                    k_next    = k_reg + 1'b1;
                    r400_next = gdn_pkg::YEAR_W'(r400_inc);
                end
                else
                begin
                    mn_next    = '0;
                    state_next = S_MWALK;
                end
            end

            // Take off whole months, stopping at December
            S_MWALK:
            begin
                alu_op.a   = acc_reg;
                alu_op.b   = AW'(mlen);
                alu_op.sub = 1'b1;
                if ((mn_reg < gdn_pkg::DECEMBER_IDX) && alu_res.carry && (alu_res.sum != '0))
                begin
                    acc_next = alu_res.sum;
                    mn_next  = mn_reg + 1'b1;
                end
                else
                    state_next = S_DONE;
            end

            // Hold the count remainder mod 7
            S_MOD7:
            begin
                rem_next   = count_mod7;
                state_next = S_DONE;
            end

            // Load the result register once it is free
            S_DONE:
            begin
                if (slot_free)
                begin
                    out_next = '0;
                    case (func_reg)
                        gdn_pkg::FUNC_TO_COUNT:
                            out_next.day_count = acc_reg;
                        gdn_pkg::FUNC_TO_DATE:
                        begin
                            out_next.out_year  = k_reg[gdn_pkg::YEAR_W-1:0];
                            out_next.out_month = mn_reg + 1'b1;
                            out_next.out_day   = (acc_reg > AW'(gdn_pkg::MDAY_MAX))
                                                 ? gdn_pkg::MDAY_MAX
                                                 : acc_reg[gdn_pkg::MDAY_W-1:0];
                        end
                        gdn_pkg::FUNC_WEEKDAY:
                            out_next.weekday = wd_mod[gdn_pkg::WD_W-1:0] + 1'b1;
                        default: ;
                    endcase
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            epoch_reg     <= gdn_pkg::EPOCH_RESET;
            refyr_reg     <= gdn_pkg::REFYR_RESET;
            refwd_reg     <= gdn_pkg::REFWD_RESET;
            func_reg      <= gdn_pkg::FUNC_NONE;
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            r400_reg      <= '0;
            k_reg         <= '0;
            acc_reg       <= '0;
            mn_reg        <= '0;
            rem_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            epoch_reg     <= epoch_next;
            refyr_reg     <= refyr_next;
            refwd_reg     <= refwd_next;
            func_reg      <= func_next;
            year_reg      <= year_next;
            month_reg     <= month_next;
            day_reg       <= day_next;
            r400_reg      <= r400_next;
            k_reg         <= k_next;
            acc_reg       <= acc_next;
            mn_reg        <= mn_next;
            rem_reg       <= rem_next;
            out_reg       <= out_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

[rtl/gdn_checker.sv]
module gdn_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input gdn_pkg::rsp_t rsp_data
);
    logic [1:0] pend_reg, pend_next;
    logic       cmd_beat;
    logic       rsp_beat;

    assign cmd_beat = cmd_valid && cmd_ready;
    assign rsp_beat = rsp_valid && rsp_ready;

    // Track beats taken but not yet answered
    always_comb
    begin
        pend_next = pend_reg;
        if (cmd_beat && !rsp_beat)
            pend_next = pend_reg + 1'b1;
        else if (rsp_beat && !cmd_beat)
            pend_next = pend_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp valid dropped under stall");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_data))
        else $error("rsp payload changed under stall");

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_beat |=> !cmd_ready)
        else $error("cmd ready right after a cmd beat");

    a_no_spurious_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("rsp without an outstanding cmd");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_beat |-> pend_reg < 2'd2)
        else $error("cmd taken with two beats outstanding");
endmodule

bind gregorian_day_number_converter gdn_checker u_gdn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);
